// File: design/hsv_to_rgb565_converter_macros.svh
// assertion macros of the hsv to rgb565 converter rtl
`ifndef HSV_TO_RGB565_CONVERTER_MACROS_SVH
`define HSV_TO_RGB565_CONVERTER_MACROS_SVH

// checked only outside reset
`define HSVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define HSVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/hsvc_pkg.sv
// types and constants of the hsv to rgb565 converter
`default_nettype none

package hsvc_pkg;

  localparam int NSTAGE = 5;

  localparam logic [9:0]  CIRCLE_DEG  = 10'd360;
  localparam logic [9:0]  CIRCLE_DEG2 = 10'd720;
  localparam logic [5:0]  SECTOR_DEG  = 6'd60;
  localparam logic [7:0]  SCALE_FULL  = 8'd255;
  localparam logic [13:0] FRAC_DEN    = 14'd15300;

  // x/3825 and x/255 estimates: (x*recip) >> shift, low by at most one
  localparam logic [11:0] DIV_Q   = 12'd3825;
  localparam logic [8:0]  RECIP_Q = 9'd274;
  localparam logic [8:0]  RECIP_P = 9'd257;

  localparam logic [4:0] RED_MASK   = 5'h1f;
  localparam logic [5:0] GREEN_MASK = 6'h3f;

  typedef enum logic [2:0] {
    SECT_RED     = 3'd0,
    SECT_YELLOW  = 3'd1,
    SECT_GREEN   = 3'd2,
    SECT_CYAN    = 3'd3,
    SECT_BLUE    = 3'd4,
    SECT_MAGENTA = 3'd5
  } hsvc_sector_t;

  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } hsvc_pipe_t;

endpackage

`default_nettype wire

// File: design/hsvc_sector.sv
// hue reduction modulo 360 and split into sector and offset
`default_nettype none

module hsvc_sector import hsvc_pkg::*; (
  input  wire logic [9:0]   hue,
  output hsvc_sector_t      sect,
  output logic [5:0]        offs
);

  logic [9:0] hm;
  logic [8:0] base;

  always_comb begin
    if (hue >= CIRCLE_DEG2) begin
      hm = hue - CIRCLE_DEG2;
    end else if (hue >= CIRCLE_DEG) begin
      hm = hue - CIRCLE_DEG;
    end else begin
      hm = hue;
    end

    if (hm >= 10'd300) begin
      sect = SECT_MAGENTA;
      base = 9'd300;
    end else if (hm >= 10'd240) begin
      sect = SECT_BLUE;
      base = 9'd240;
    end else if (hm >= 10'd180) begin
      sect = SECT_CYAN;
      base = 9'd180;
    end else if (hm >= 10'd120) begin
      sect = SECT_GREEN;
      base = 9'd120;
    end else if (hm >= 10'd60) begin
      sect = SECT_YELLOW;
      base = 9'd60;
    end else begin
      sect = SECT_RED;
      base = 9'd0;
    end

    offs = 6'(hm[8:0] - base);
  end

endmodule

`default_nettype wire

// File: design/hsvc_ctrl.sv
// valid bits and per-stage load enables of the pipeline
`default_nettype none

module hsvc_ctrl import hsvc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output hsvc_pipe_t pipe
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] ready;
  logic              in_acc;
  logic              out_acc;

  // a stage can load when empty or when the stage after it moves on
  always_comb begin
    ready[NSTAGE-1] = !valid[NSTAGE-1] || !out_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign in_stall   = !ready[0];
  assign out_valid  = valid[NSTAGE-1];
  assign pipe.load  = ready;
  assign in_acc     = in_valid && !in_stall;
  assign out_acc    = out_valid && !out_stall;

`include "hsv_to_rgb565_converter_macros.svh"

  `HSVC_ASSERT_ALWAYS(a_reset_empty, rst |=> (valid == '0), "pipeline not empty after reset")
  `HSVC_ASSERT(a_stall_only_full, in_stall |-> (&valid), "input stalled with a bubble inside")
  `HSVC_ASSERT(a_count_hold, (!in_acc && !out_acc) |=> ($countones(valid) == $past($countones(valid))), "beat lost or invented")
  `HSVC_ASSERT(a_count_grow, (in_acc && !out_acc) |=> ($countones(valid) == $past($countones(valid)) + 1), "accepted beat not counted")

endmodule

`default_nettype wire

// File: design/hsv_to_rgb565_converter.sv
// hsv to rgb565 converter top level: five-stage pixel pipeline
// an accepted input beat moves through stages 0 to 4; stage 4 registers its pixel for the output
// throughput: one pixel per cycle while out_stall is low, set by the five-stage pipeline where every stage
//   holds one beat; a stalled output backs up only as far as the first bubble
// reset: rst clears the stage valid bits only, datapath registers are not reset
`default_nettype none

module hsv_to_rgb565_converter import hsvc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [9:0] hue,
  input  wire logic [7:0] saturation,
  input  wire logic [7:0] brightness,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [15:0]     pixel
);

  hsvc_pipe_t   pipe;
  hsvc_sector_t sect_in;
  logic [5:0]   offs_in;

  // stage 0: reduced hue
  logic [7:0]   s0;
  logic [7:0]   v0;
  hsvc_sector_t sect0;
  logic [5:0]   h0;

  // stage 1: numerators of the three fractions
  logic [7:0]   v1;
  hsvc_sector_t sect1;
  logic [7:0]   c1;
  logic [13:0]  a1;
  logic [13:0]  b1;

  // stage 2: scaled products
  logic [7:0]   v2;
  hsvc_sector_t sect2;
  logic [15:0]  np2;
  logic [21:0]  nq2;
  logic [21:0]  nt2;

  // stage 3: quotient estimates and their dividends
  logic [7:0]   v3;
  hsvc_sector_t sect3;
  logic [15:0]  xp3;
  logic [19:0]  yq3;
  logic [19:0]  yt3;
  logic [7:0]   ep3;
  logic [7:0]   eq3;
  logic [7:0]   et3;

  logic [23:0]  prod_p;
  logic [27:0]  prod_q;
  logic [27:0]  prod_t;
  logic [15:0]  rem_p;
  logic [19:0]  rem_q;
  logic [19:0]  rem_t;
  logic [7:0]   p;
  logic [7:0]   q;
  logic [7:0]   t;
  logic [7:0]   r;
  logic [7:0]   g;
  logic [7:0]   b;
  logic [15:0]  pixel_next;

  hsvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pipe      (pipe)
  );

  hsvc_sector u_sector (
    .hue  (hue),
    .sect (sect_in),
    .offs (offs_in)
  );

  // reciprocal estimates, corrected one stage later
  assign prod_p = 24'(np2) * 24'(RECIP_P);
  assign prod_q = 28'(nq2[21:2]) * 28'(RECIP_Q);
  assign prod_t = 28'(nt2[21:2]) * 28'(RECIP_Q);

  // remainder stays below twice the divisor, so one step fixes the quotient
  always_comb begin
    rem_p = xp3 - 16'(ep3) * 16'(SCALE_FULL);
    rem_q = yq3 - 20'(eq3) * 20'(DIV_Q);
    rem_t = yt3 - 20'(et3) * 20'(DIV_Q);
    p = ep3 + 8'(rem_p >= 16'(SCALE_FULL));
    q = eq3 + 8'(rem_q >= 20'(DIV_Q));
    t = et3 + 8'(rem_t >= 20'(DIV_Q));

    case (sect3)
      SECT_RED: begin
        r = v3; g = t; b = p;
      end
      SECT_YELLOW: begin
        r = q; g = v3; b = p;
      end
      SECT_GREEN: begin
        r = p; g = v3; b = t;
      end
      SECT_CYAN: begin
        r = p; g = q; b = v3;
      end
      SECT_BLUE: begin
        r = t; g = p; b = v3;
      end
      default: begin
        r = v3; g = p; b = q;
      end
    endcase

    pixel_next = {r[7:3] & RED_MASK, g[7:2] & GREEN_MASK, b[7:3] & RED_MASK};
  end

  always_ff @(posedge clk) begin
    if (pipe.load[0]) begin
      s0    <= saturation;
      v0    <= brightness;
      sect0 <= sect_in;
      h0    <= offs_in;
    end
    if (pipe.load[1]) begin
      v1    <= v0;
      sect1 <= sect0;
      c1    <= SCALE_FULL - s0;
      a1    <= FRAC_DEN - 14'(s0) * 14'(h0);
      b1    <= FRAC_DEN - 14'(s0) * 14'(SECTOR_DEG - h0);
    end
    if (pipe.load[2]) begin
      v2    <= v1;
      sect2 <= sect1;
      np2   <= 16'(v1) * 16'(c1);
      nq2   <= 22'(v1) * 22'(a1);
      nt2   <= 22'(v1) * 22'(b1);
    end
    if (pipe.load[3]) begin
      v3    <= v2;
      sect3 <= sect2;
      xp3   <= np2;
      // x/15300 is (x/4)/3825
      yq3   <= nq2[21:2];
      yt3   <= nt2[21:2];
      ep3   <= prod_p[23:16];
      eq3   <= prod_q[27:20];
      et3   <= prod_t[27:20];
    end
    if (pipe.load[4]) begin
      pixel <= pixel_next;
    end
  end

endmodule

`default_nettype wire
